// ===== hw/rtl/four_level_page_table_walker_defines.svh =====
// assertion macros for the four-level page table walker
// no dependencies; included by the top level only
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PTW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptw_pkg.sv =====
// shared types and constants of the page table walker
// no dependencies; used by the interfaces and the top level
package ptw_pkg;

    // request operation codes
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_ENTRY = 1'b1
    } t_op;

    // response kind codes
    typedef enum logic [1:0] {
        KIND_READ       = 2'd0,
        KIND_DONE       = 2'd1,
        KIND_FAULT      = 2'd2,
        KIND_UNEXPECTED = 2'd3
    } t_kind;

    // walk levels, top table first
    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } t_level;

    localparam int unsigned VA_W    = 48;
    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned PAGE_SH = 12;

    // page table entry bit positions
    localparam int unsigned PTE_PRESENT = 0;
    localparam int unsigned PTE_LARGE   = 7;
    localparam int unsigned PTE_FRM_HI  = 51;

endpackage

// ===== hw/rtl/ptw_in_if.sv =====
// request channel of the page table walker
// depends on ptw_pkg
interface ptw_in_if
    import ptw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [VA_W-1:0]     virt_addr;
    logic [ROOT_W-1:0]   root_base;
    logic [DATA_W-1:0]   entry_data;

    modport source (output valid, operation, virt_addr, root_base, entry_data,
                    input ready);
    modport sink   (input valid, operation, virt_addr, root_base, entry_data,
                    output ready);
endinterface

// ===== hw/rtl/ptw_out_if.sv =====
// response channel of the page table walker
// depends on ptw_pkg
interface ptw_out_if
    import ptw_pkg::*;
();
    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [DATA_W-1:0]   address;

    modport source (output valid, kind, address, input ready);
    modport sink   (input valid, kind, address, output ready);
endinterface

// ===== hw/rtl/four_level_page_table_walker.sv =====
// Four-level page table walker for 48-bit virtual addresses. A start request
// gives the first entry read address; each entry request gives the next read
// address, a finished physical address, a fault, or, with no walk in progress,
// an unexpected kind. A response enters the output register in the cycle after
// its request is taken; a new request is taken every cycle while the response
// register is empty or being drained. The path that sets the cycle is the
// single 64-bit add of the direct-map base to the table address and index.
// depends on ptw_pkg, ptw_in_if, ptw_out_if and the assertion macro header
`include "four_level_page_table_walker_defines.svh"

module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    ptw_in_if.sink            i_req,
    ptw_out_if.source         o_rsp
);

    localparam int unsigned TBL_W = DATA_W - PAGE_SH;

    // walk state
    logic              r_busy,  n_busy;
    t_level            r_level, n_level;
    logic [VA_W-1:0]   r_va,    n_va;
    logic [DATA_W-1:0] r_base;

    // response register
    logic              r_out_valid;
    t_kind             r_kind,  n_kind;
    logic [DATA_W-1:0] r_addr,  n_addr;

    logic              req_fire;
    logic [TBL_W-1:0]  rd_tbl;
    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] rd_addr;
    logic [VA_W-1:0]   idx_va;
    t_level            idx_lvl;
    logic [TBL_W-1:0]  entry_frame;
    logic              entry_present;
    logic              entry_large;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_fire    = i_req.valid && i_req.ready;

    assign entry_frame   = {{(TBL_W-(PTE_FRM_HI+1-PAGE_SH)){1'b0}},
                            i_req.entry_data[PTE_FRM_HI:PAGE_SH]};
    assign entry_present = i_req.entry_data[PTE_PRESENT];
    assign entry_large   = i_req.entry_data[PTE_LARGE];

    // index slice for the level being read
    always_comb begin
        unique case (idx_lvl)
            LVL_PML4: rd_idx = idx_va[47:39];
            LVL_PDPT: rd_idx = idx_va[38:30];
            LVL_PD:   rd_idx = idx_va[29:21];
            LVL_PT:   rd_idx = idx_va[20:12];
            default:  rd_idx = '0;
        endcase
    end

    // entry read address, table low bits are always clear
    assign rd_addr = r_base + {rd_tbl, rd_idx, 3'b000};

    // walk step for the incoming request
    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_va    = r_va;
        n_kind  = KIND_READ;
        n_addr  = '0;
        idx_va  = r_va;
        idx_lvl = t_level'(r_level + 2'd1);
        rd_tbl  = entry_frame;
        if (i_req.operation == OP_START) begin
            n_va    = i_req.virt_addr;
            n_level = LVL_PML4;
            n_busy  = 1'b1;
            idx_va  = i_req.virt_addr;
            idx_lvl = LVL_PML4;
            rd_tbl  = {{(TBL_W-(ROOT_W-PAGE_SH)){1'b0}}, i_req.root_base[ROOT_W-1:PAGE_SH]};
            n_addr  = rd_addr;
        end else if (!r_busy) begin
            n_kind = KIND_UNEXPECTED;
        end else if (!entry_present) begin
            n_kind  = KIND_FAULT;
            n_busy  = 1'b0;
            n_level = LVL_PML4;
        end else if (entry_large && (r_level == LVL_PDPT)) begin
            // 1 GiB page
            n_kind  = KIND_DONE;
            n_addr  = {12'b0, i_req.entry_data[PTE_FRM_HI:30], r_va[29:0]};
            n_busy  = 1'b0;
            n_level = LVL_PML4;
        end else if (entry_large && (r_level == LVL_PD)) begin
            // 2 MiB page
            n_kind  = KIND_DONE;
            n_addr  = {12'b0, i_req.entry_data[PTE_FRM_HI:21], r_va[20:0]};
            n_busy  = 1'b0;
            n_level = LVL_PML4;
        end else if (r_level == LVL_PT) begin
            // 4 KiB leaf
            n_kind  = KIND_DONE;
            n_addr  = {12'b0, i_req.entry_data[PTE_FRM_HI:PAGE_SH], r_va[PAGE_SH-1:0]};
            n_busy  = 1'b0;
            n_level = LVL_PML4;
        end else begin
            n_level = t_level'(r_level + 2'd1);
            n_addr  = rd_addr;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= LVL_PML4;
            r_va    <= '0;
        end else if (req_fire) begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_va    <= n_va;
        end
    end

    // response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_kind <= n_kind;
            r_addr <= n_addr;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.kind    = r_kind;
    assign o_rsp.address = r_addr;

    // checks
    `PTW_ASSERT_NEXT(a_idle_entry_flagged, i_clk, i_rst_n,
        req_fire && (i_req.operation == OP_ENTRY) && !r_busy,
        r_out_valid && (r_kind == KIND_UNEXPECTED), "entry while idle not flagged")
    `PTW_ASSERT_NEXT(a_start_resets_walk, i_clk, i_rst_n,
        req_fire && (i_req.operation == OP_START),
        r_busy && (r_level == LVL_PML4) && (r_kind == KIND_READ), "start did not begin walk")
    `PTW_ASSERT_NEXT(a_end_goes_idle, i_clk, i_rst_n,
        req_fire && ((n_kind == KIND_DONE) || (n_kind == KIND_FAULT)),
        !r_busy, "walk still busy after final response")
    `PTW_ASSERT_SAME(a_idle_level_zero, i_clk, i_rst_n,
        !r_busy, r_level == LVL_PML4, "idle walker holds nonzero level")

endmodule
